// ----- sv/cfb_pkg.sv -----
// shared types and constants for the checksummed frame builder
// no dependencies; imported by the front, queue, back and top-level modules
package cfb_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h5A;
  localparam int         QUEUE_DEPTH = 2;

  // byte positions inside the bytes caused by one word
  typedef enum logic [2:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_FUNC,
    ST_LEN,
    ST_WHI,
    ST_WLO,
    ST_CSUM
  } step_t;

  // work item handed from front to back
  typedef struct packed {
    logic        start;    // first word of a frame, header goes first
    logic        zero;     // empty frame, header then checksum, word dropped
    logic        last;     // checksum follows this word
    logic [7:0]  func;
    logic [7:0]  len;
    logic [15:0] word;
  } desc_t;

endpackage

// ----- sv/cfb_front.sv -----
// front part: accepts words, tracks the open frame and builds work items
// depends on cfb_pkg
module cfb_front #(
  parameter int MAX_WORDS = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_word_value,
  input  logic [7:0]           in_function_code,
  input  logic [2:0]           in_word_count,
  input  logic                 q_full,
  output logic                 q_push,
  output cfb_pkg::desc_t       q_desc
);
  import cfb_pkg::*;

  localparam int WLW = $clog2(MAX_WORDS + 1);

  logic [WLW-1:0] words_left_r, words_left_nxt;
  logic [2:0]     cnt_sat;
  logic           idle;

  assign idle     = (words_left_r == '0);
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    if (int'(in_word_count) > MAX_WORDS) begin
      cnt_sat = 3'(MAX_WORDS);
    end else begin
      cnt_sat = in_word_count;
    end
  end

  always_comb begin
    q_desc.start = idle;
    q_desc.zero  = idle && (cnt_sat == 3'd0);
    q_desc.func  = in_function_code;
    q_desc.len   = {4'b0000, cnt_sat, 1'b0};
    q_desc.word  = in_word_value;
    words_left_nxt = words_left_r;
    if (idle) begin
      q_desc.last = (cnt_sat == 3'd1);
      if (cnt_sat != 3'd0) begin
        words_left_nxt = WLW'(cnt_sat) - WLW'(1);
      end
    end else begin
      q_desc.last    = (words_left_r == WLW'(1));
      words_left_nxt = words_left_r - WLW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r <= '0;
    end else if (q_push) begin
      words_left_r <= words_left_nxt;
    end
  end

endmodule

// ----- sv/cfb_fifo.sv -----
// short work item queue between front and back
// depends on cfb_pkg
module cfb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfb_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cfb_pkg::desc_t head_desc
);
  import cfb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/cfb_back.sv -----
// back part: serializes work items into frame bytes with running checksum
// depends on cfb_pkg
module cfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  cfb_pkg::desc_t head_desc,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte_out,
  output logic           out_run_end,
  output logic           out_frame_end
);
  import cfb_pkg::*;

  step_t      step_r, step_nxt, cur_step;
  logic       busy_r;
  logic [7:0] sum_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       run_end_r, frame_end_r;

  logic       load, item_done;
  logic [7:0] cur_byte;

  assign cur_step = busy_r ? step_r : (head_desc.start ? ST_SYNC0 : ST_WHI);
  assign load     = head_valid && (!out_valid_r || out_ready);
  assign pop      = load && item_done;

  // next step
  always_comb begin
    unique case (cur_step)
      ST_SYNC0: step_nxt = ST_SYNC1;
      ST_SYNC1: step_nxt = ST_FUNC;
      ST_FUNC:  step_nxt = ST_LEN;
      ST_LEN:   step_nxt = head_desc.zero ? ST_CSUM : ST_WHI;
      ST_WHI:   step_nxt = ST_WLO;
      ST_WLO:   step_nxt = head_desc.last ? ST_CSUM : ST_SYNC0;
      ST_CSUM:  step_nxt = ST_SYNC0;
      default:  step_nxt = ST_SYNC0;
    endcase
  end

  // byte for the current step
  always_comb begin
    unique case (cur_step)
      ST_SYNC0: cur_byte = SYNC_BYTE;
      ST_SYNC1: cur_byte = SYNC_BYTE;
      ST_FUNC:  cur_byte = head_desc.func;
      ST_LEN:   cur_byte = head_desc.len;
      ST_WHI:   cur_byte = head_desc.word[15:8];
      ST_WLO:   cur_byte = head_desc.word[7:0];
      ST_CSUM:  cur_byte = sum_r;
      default:  cur_byte = sum_r;
    endcase
    item_done = (cur_step == ST_CSUM) || ((cur_step == ST_WLO) && !head_desc.last);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r      <= cur_byte;
      run_end_r   <= item_done;
      frame_end_r <= (cur_step == ST_CSUM);
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      busy_r      <= !item_done;
      out_valid_r <= 1'b1;
      if (cur_step == ST_CSUM) begin
        sum_r <= '0;
      end else begin
        sum_r <= sum_r + cur_byte;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte_out  = byte_r;
  assign out_run_end   = run_end_r;
  assign out_frame_end = frame_end_r;

endmodule

// ----- sv/checksummed_frame_builder_core.sv -----
// checksummed frame builder, top level
// depends on cfb_pkg, cfb_front, cfb_fifo, cfb_back
//
// usage:
//   in channel (in_valid/in_ready) takes one signed 16-bit word per handshake.
//   the first word of a frame also carries the function byte and word count;
//   on later words of the frame those two fields are ignored.
//   out channel (out_valid/out_ready) delivers one frame byte per handshake:
//   0x5a 0x5a, function, byte length, each word high byte first, then the
//   modulo-256 checksum of all earlier frame bytes.
//   out_run_end marks the last byte caused by one input word, out_frame_end
//   marks the checksum byte.
// flow:
//   an accepted word is stored in the work queue; its first byte then
//   passes through the output register. the back end emits one byte per
//   cycle while out_ready is high and a work item waits. a two-entry work
//   queue lets a new word be accepted while bytes of earlier words still
//   drain.
// reset and stall:
//   synchronous active-low reset empties the queue, closes any open frame
//   and clears the checksum. when out_ready is low the output byte holds,
//   the queue fills and in_ready drops once it is full.
module checksummed_frame_builder_core #(
  parameter int MAX_WORDS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_word_value,
  input  logic [7:0]         in_function_code,
  input  logic [2:0]         in_word_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte_out,
  output logic               out_run_end,
  output logic               out_frame_end
);
  import cfb_pkg::*;

  // front to queue
  logic  q_push, q_full;
  desc_t q_desc;

  // queue to back
  logic  head_valid, q_pop;
  desc_t head_desc;

  // front keeps the count of words still owed to the open frame
  cfb_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_word_value    (in_word_value),
    .in_function_code (in_function_code),
    .in_word_count    (in_word_count),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_desc           (q_desc)
  );

  // decouples acceptance from byte emission
  cfb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // byte sequencer with running checksum and output register
  cfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_desc     (head_desc),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte_out  (out_byte_out),
    .out_run_end   (out_run_end),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- sv/cfb_checker.sv -----
// port-level checks for the checksummed frame builder
// depends on checksummed_frame_builder_core (bound to it below)
module cfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte_out,
  input logic        out_run_end,
  input logic        out_frame_end
);

  logic [7:0] sum_r;

  // checksum of delivered bytes since the last frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (out_valid && out_ready) begin
      if (out_frame_end) begin
        sum_r <= '0;
      end else begin
        sum_r <= sum_r + out_byte_out;
      end
    end
  end

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte_out)
      && $stable(out_run_end) && $stable(out_frame_end)))
    else $error("stalled output word changed");

  a_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_run_end)
    else $error("checksum word not marked as end of run");

  a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_frame_end) |-> (out_byte_out == sum_r))
    else $error("checksum mismatch");

endmodule

bind checksummed_frame_builder_core cfb_checker u_cfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte_out  (out_byte_out),
  .out_run_end   (out_run_end),
  .out_frame_end (out_frame_end)
);
